// ===== hw/rtl/cdc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared sizes, codes and types of the causal dilated convolution block.
// ----------------------------------------------------------------------------
package cdc_pkg;

    localparam int MAX_IN_CH     = 32;
    localparam int MAX_OUT_CH    = 32;
    localparam int MAX_TAPS      = 8;
    localparam int HISTORY_STEPS = 128;

    localparam int IN_W    = $clog2(MAX_IN_CH);
    localparam int OUT_W   = $clog2(MAX_OUT_CH);
    localparam int TAP_W   = $clog2(MAX_TAPS);
    localparam int HIST_W  = $clog2(HISTORY_STEPS);
    localparam int STEPS_W = $clog2(HISTORY_STEPS + 1);
    localparam int WADDR_W = OUT_W + IN_W + TAP_W;
    localparam int HADDR_W = HIST_W + IN_W;

    localparam int RESQ_DEPTH = 8;
    localparam int RESQ_W     = $clog2(RESQ_DEPTH);

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_WEIGHT = 2'd1;
    localparam logic [1:0] KIND_BIAS   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] CFG_IN_COUNT  = 2'd0;
    localparam logic [1:0] CFG_OUT_COUNT = 2'd1;
    localparam logic [1:0] CFG_TAPS      = 2'd2;
    localparam logic [1:0] CFG_DILATION  = 2'd3;

    // effective (clamped) configuration
    typedef struct packed {
        logic [5:0] n_in;
        logic [5:0] n_out;
        logic [3:0] n_taps;
        logic [4:0] dil;
    } cfg_t;

    typedef struct packed {
        logic               w_we;
        logic [WADDR_W-1:0] w_addr;
        logic               b_we;
        logic [OUT_W-1:0]   b_addr;
        logic               h_we;
        logic [HADDR_W-1:0] h_addr;
        logic signed [15:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic [HIST_W-1:0]  ptr;
        logic [STEPS_W-1:0] steps;
    } job_t;

    typedef struct packed {
        logic [OUT_W-1:0]   chan;
        logic signed [15:0] value;
        logic               sat;
        logic               last;
    } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/causal_dilated_conv1d.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// causal_dilated_conv1d
// Causal dilated 1-D convolution with bias, Q7.8 samples and Q1.14 weights.
// ----------------------------------------------------------------------------
// Load and intermediate sample items are taken in one cycle each. The sample
// that completes a time step posts a job to the back end, whose single
// multiply-accumulate unit works through every output channel, tap and input
// channel of it (one product per cycle, taps reaching past the history counted
// as zero). The back end takes the job when idle; each product then passes the
// store read, product and accumulator registers, and the rounded result of a
// channel enters the queue. Every item stalls while a finished step waits for
// the back end; weight and bias loads also stall while a job is still being
// read. Results leave through an eight-entry queue, and the back end holds at
// the start of an output channel while eight results wait.
// ----------------------------------------------------------------------------
module causal_dilated_conv1d
    import cdc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         kind,
    input  wire logic               start_of_sequence,
    input  wire logic [4:0]         out_index,
    input  wire logic [4:0]         in_index,
    input  wire logic [2:0]         tap_index,
    input  wire logic signed [15:0] value,
    output logic                    empty,
    input  wire logic               pop,
    output logic [4:0]              out_channel,
    output logic signed [15:0]      out_value,
    output logic                    saturated,
    output logic                    last,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [5:0]         cfg_data
);

    cfg_t    cfg;
    mem_wr_t wr;
    job_t    job;
    result_t res;
    result_t head;
    logic    job_valid;
    logic    job_take;
    logic    back_busy;
    logic    res_push;
    logic    res_pop;

    assign res_pop = pop && !empty;

    cdc_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .kind              (kind),
        .start_of_sequence (start_of_sequence),
        .out_index         (out_index),
        .in_index          (in_index),
        .tap_index         (tap_index),
        .value             (value),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .back_busy         (back_busy),
        .job_take          (job_take),
        .cfg               (cfg),
        .wr                (wr),
        .job_valid         (job_valid),
        .job               (job)
    );

    cdc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .wr        (wr),
        .job_valid (job_valid),
        .job       (job),
        .res_pop   (res_pop),
        .busy      (back_busy),
        .job_take  (job_take),
        .res_push  (res_push),
        .res       (res)
    );

    cdc_resq u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .rd_en   (res_pop),
        .empty   (empty),
        .rd_data (head)
    );

    assign out_channel = head.chan;
    assign out_value   = head.value;
    assign saturated   = head.sat;
    assign last        = head.last;

endmodule
`default_nettype wire

// ===== hw/rtl/cdc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_front
// Accepts and classifies input items, holds configuration and step state,
// issues store writes and posts one job per completed time step.
// ----------------------------------------------------------------------------
module cdc_front
    import cdc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         kind,
    input  wire logic               start_of_sequence,
    input  wire logic [4:0]         out_index,
    input  wire logic [4:0]         in_index,
    input  wire logic [2:0]         tap_index,
    input  wire logic signed [15:0] value,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [5:0]         cfg_data,
    input  wire logic               back_busy,
    input  wire logic               job_take,
    output cfg_t                    cfg,
    output mem_wr_t                 wr,
    output logic                    job_valid,
    output job_t                    job
);

    logic [5:0]         in_ch_reg;
    logic [5:0]         out_ch_reg;
    logic [3:0]         taps_reg;
    logic [4:0]         dil_reg;
    logic [HIST_W-1:0]  ptr_reg;
    logic [STEPS_W-1:0] steps_reg;
    logic [IN_W-1:0]    chan_reg;
    logic               job_valid_reg;
    job_t               job_reg;

    logic               accept;
    logic               is_load;
    logic               is_sample;
    logic [IN_W-1:0]    chan_eff;
    logic [STEPS_W-1:0] steps_eff;
    logic               completes;

    always_comb
    begin
        cfg.n_in   = (in_ch_reg == 6'd0) ? 6'd1 :
                     (in_ch_reg > 6'(MAX_IN_CH)) ? 6'(MAX_IN_CH) : in_ch_reg;
        cfg.n_out  = (out_ch_reg == 6'd0) ? 6'd1 :
                     (out_ch_reg > 6'(MAX_OUT_CH)) ? 6'(MAX_OUT_CH) : out_ch_reg;
        cfg.n_taps = (taps_reg == 4'd0) ? 4'd1 :
                     (taps_reg > 4'(MAX_TAPS)) ? 4'(MAX_TAPS) : taps_reg;
        cfg.dil    = (dil_reg == 5'd0) ? 5'd1 : dil_reg;
    end

    // All items wait for the job slot; loads also wait until the back end has read all it needs.
    assign is_load   = (kind == KIND_WEIGHT) || (kind == KIND_BIAS);
    assign is_sample = (kind == KIND_SAMPLE);
    assign full      = job_valid_reg || (back_busy && is_load);
    assign accept    = push && !full;

    assign chan_eff  = start_of_sequence ? '0 : chan_reg;
    assign steps_eff = start_of_sequence ? '0 : steps_reg;
    assign completes = ({1'b0, chan_eff} + 6'd1) >= cfg.n_in;

    always_comb
    begin
        wr.w_we   = accept && (kind == KIND_WEIGHT);
        wr.w_addr = {out_index, in_index, tap_index};
        wr.b_we   = accept && (kind == KIND_BIAS);
        wr.b_addr = out_index;
        wr.h_we   = accept && is_sample;
        wr.h_addr = {ptr_reg, chan_eff};
        wr.data   = value;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch_reg     <= 6'd1;
            out_ch_reg    <= 6'd1;
            taps_reg      <= 4'd1;
            dil_reg       <= 5'd1;
            ptr_reg       <= '0;
            steps_reg     <= '0;
            chan_reg      <= '0;
            job_valid_reg <= 1'b0;
            job_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IN_COUNT:  in_ch_reg  <= cfg_data;
                    CFG_OUT_COUNT: out_ch_reg <= cfg_data;
                    CFG_TAPS:      taps_reg   <= cfg_data[3:0];
                    CFG_DILATION:  dil_reg    <= cfg_data[4:0];
                    default:       ;
                endcase
            end
            if (job_take)
            begin
                job_valid_reg <= 1'b0;
            end
            if (accept && is_sample)
            begin
                if (completes)
                begin
                    job_valid_reg <= 1'b1;
                    job_reg.ptr   <= ptr_reg;
                    job_reg.steps <= steps_eff;
                    ptr_reg       <= ptr_reg + 1'b1;
                    steps_reg     <= (steps_eff < STEPS_W'(HISTORY_STEPS)) ?
                                     steps_eff + 1'b1 : steps_eff;
                    chan_reg      <= '0;
                end
                else
                begin
                    chan_reg  <= chan_eff + 1'b1;
                    steps_reg <= steps_eff;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/cdc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_back
// Holds the weight, bias and history stores and runs one time-step job as a
// sequence of multiply-accumulates: issue, read, multiply, accumulate, round.
// ----------------------------------------------------------------------------
module cdc_back
    import cdc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire mem_wr_t wr,
    input  wire logic    job_valid,
    input  wire job_t    job,
    input  wire logic    res_pop,
    output logic         busy,
    output logic         job_take,
    output logic         res_push,
    output result_t      res
);

    logic signed [15:0] wmem [MAX_OUT_CH*MAX_IN_CH*MAX_TAPS];
    logic signed [15:0] bmem [MAX_OUT_CH];
    logic signed [15:0] hmem [HISTORY_STEPS*MAX_IN_CH];

    logic               busy_reg;
    logic [OUT_W-1:0]   o_reg;
    logic [TAP_W-1:0]   k_reg;
    logic [IN_W-1:0]    i_reg;
    logic [HIST_W-1:0]  jptr_reg;
    logic [STEPS_W-1:0] jsteps_reg;
    logic [RESQ_W:0]    pending_reg;

    logic               s1_valid_reg, s1_first_reg, s1_lastg_reg, s1_ok_reg, s1_lasto_reg;
    logic [OUT_W-1:0]   s1_o_reg;
    logic signed [15:0] w_q, h_q, b_q;

    logic               s2_valid_reg, s2_first_reg, s2_lastg_reg, s2_lasto_reg;
    logic [OUT_W-1:0]   s2_o_reg;
    logic signed [31:0] prod_reg;
    logic signed [15:0] s2_bias_reg;

    logic               s3_done_reg, s3_lasto_reg;
    logic [OUT_W-1:0]   s3_o_reg;
    logic signed [47:0] acc_reg;

    logic               group_start, emit, last_i, last_k, last_o, tap_ok;
    logic [3:0]         tap_dist;
    logic [8:0]         delay;
    logic [HIST_W-1:0]  slot;
    logic signed [47:0] acc_base, rnd;
    logic signed [33:0] q;

    always_ff @(posedge clk)
    begin
        if (wr.w_we) wmem[wr.w_addr] <= wr.data;
        if (wr.b_we) bmem[wr.b_addr] <= wr.data;
        if (wr.h_we) hmem[wr.h_addr] <= wr.data;
        w_q <= wmem[{o_reg, i_reg, k_reg}];
        h_q <= hmem[{slot, i_reg}];
        b_q <= bmem[o_reg];
    end

    assign group_start = (k_reg == '0) && (i_reg == '0);
    // hold a new output channel until the result queue has room for it
    assign emit   = busy_reg && (!group_start || (pending_reg < (RESQ_W+1)'(RESQ_DEPTH)));
    assign last_i = ({1'b0, i_reg} == (cfg.n_in - 6'd1));
    assign last_k = ({1'b0, k_reg} == (cfg.n_taps - 4'd1));
    assign last_o = ({1'b0, o_reg} == (cfg.n_out - 6'd1));

    assign tap_dist = cfg.n_taps - 4'd1 - {1'b0, k_reg};
    assign delay    = 9'({5'd0, tap_dist} * {4'd0, cfg.dil});
    assign tap_ok   = (delay <= {1'b0, jsteps_reg}) && (delay < 9'(HISTORY_STEPS));
    assign slot     = jptr_reg - delay[HIST_W-1:0];

    assign busy     = busy_reg;
    assign job_take = job_valid && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            o_reg        <= '0;
            k_reg        <= '0;
            i_reg        <= '0;
            jptr_reg     <= '0;
            jsteps_reg   <= '0;
            pending_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_done_reg  <= 1'b0;
        end
        else
        begin
            if (job_take)
            begin
                busy_reg   <= 1'b1;
                o_reg      <= '0;
                k_reg      <= '0;
                i_reg      <= '0;
                jptr_reg   <= job.ptr;
                jsteps_reg <= job.steps;
            end
            else if (emit)
            begin
                if (last_i)
                begin
                    i_reg <= '0;
                    if (last_k)
                    begin
                        k_reg <= '0;
                        o_reg <= o_reg + 1'b1;
                        if (last_o)
                        begin
                            busy_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            pending_reg <= pending_reg + (RESQ_W+1)'(emit && group_start)
                                       - (RESQ_W+1)'(res_pop);

            s1_valid_reg <= emit;
            s2_valid_reg <= s1_valid_reg;
            s3_done_reg  <= s2_valid_reg && s2_lastg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= group_start;
        s1_lastg_reg <= last_i && last_k;
        s1_ok_reg    <= tap_ok;
        s1_lasto_reg <= last_o;
        s1_o_reg     <= o_reg;

        s2_first_reg <= s1_first_reg;
        s2_lastg_reg <= s1_lastg_reg;
        s2_lasto_reg <= s1_lasto_reg;
        s2_o_reg     <= s1_o_reg;
        s2_bias_reg  <= b_q;
        prod_reg     <= s1_ok_reg ? (w_q * h_q) : 32'sd0;

        if (s2_valid_reg)
        begin
            acc_reg <= acc_base + {{16{prod_reg[31]}}, prod_reg};
        end
        s3_o_reg     <= s2_o_reg;
        s3_lasto_reg <= s2_lasto_reg;
    end

    assign acc_base = s2_first_reg ? {{18{s2_bias_reg[15]}}, s2_bias_reg, 14'd0} : acc_reg;

    // round half up, then clip to 16 bits
    assign rnd = acc_reg + 48'sd8192;
    assign q   = rnd[47:14];

    always_comb
    begin
        res_push = s3_done_reg;
        res.chan = s3_o_reg;
        res.last = s3_lasto_reg;
        if (q > 34'sd32767)
        begin
            res.value = 16'sh7fff;
            res.sat   = 1'b1;
        end
        else if (q < -34'sd32768)
        begin
            res.value = 16'sh8000;
            res.sat   = 1'b1;
        end
        else
        begin
            res.value = q[15:0];
            res.sat   = 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/cdc_resq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_resq
// Result queue between the accumulator and the output ports.
// ----------------------------------------------------------------------------
module cdc_resq
    import cdc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire result_t wr_data,
    input  wire logic    rd_en,
    output logic         empty,
    output result_t      rd_data
);

    result_t           entries [RESQ_DEPTH];
    logic [RESQ_W-1:0] head_reg;
    logic [RESQ_W-1:0] tail_reg;
    logic [RESQ_W:0]   count_reg;

    assign empty   = (count_reg == '0);
    assign rd_data = entries[head_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en) entries[tail_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en) tail_reg <= tail_reg + 1'b1;
            if (rd_en) head_reg <= head_reg + 1'b1;
            count_reg <= count_reg + (RESQ_W+1)'(wr_en) - (RESQ_W+1)'(rd_en);
        end
    end

endmodule
`default_nettype wire
